@@ sv/n6502pd_pkg.sv @@
// ----------------------------------------------------------------------------
// n6502pd_pkg
// Types, opcode table and helpers shared by the NMOS 6502 predecoder.
// ----------------------------------------------------------------------------
package n6502pd_pkg;

  // mnemonic numbers, alphabetical order
  typedef enum logic [5:0] {
    MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI,
    MN_BNE, MN_BPL, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI,
    MN_CLV, MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR,
    MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
    MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_ROL,
    MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC, MN_SED, MN_SEI, MN_STA,
    MN_STX, MN_STY, MN_TAX, MN_TAY, MN_TSX, MN_TXA, MN_TXS, MN_TYA
  } mnem_t;

  // addressing modes
  typedef enum logic [3:0] {
    AM_IMP, AM_ACC, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX,
    AM_ABSY, AM_IND, AM_INDX, AM_INDY, AM_REL
  } amode_t;

  // input transaction
  typedef struct packed {
    logic [15:0] pc_address;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  third_byte;
    logic [1:0]  bytes_available;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [1:0]  instr_length;
    logic        is_data_byte;
    logic [7:0]  data_value;
    logic [5:0]  mnemonic_code;
    logic [3:0]  address_mode;
    logic [7:0]  operand_byte;
    logic [15:0] operand_address;
  } out_item_t;

  // one opcode table entry
  typedef struct packed {
    logic   valid;
    mnem_t  mnem;
    amode_t mode;
  } op_entry_t;

  localparam logic [15:0] BRANCH_BIAS = 16'd2;

  function automatic op_entry_t ent(input mnem_t m, input amode_t a);
    op_entry_t e;
    e.valid = 1'b1;
    e.mnem  = m;
    e.mode  = a;
    return e;
  endfunction

  // table length of an addressing mode
  function automatic logic [1:0] mode_len(input amode_t a);
    logic [1:0] len;
    case (a)
      AM_IMP, AM_ACC:                  len = 2'd1;
      AM_ABS, AM_ABSX, AM_ABSY, AM_IND: len = 2'd3;
      default:                         len = 2'd2;
    endcase
    return len;
  endfunction

  // official opcode set
  function automatic op_entry_t op_lookup(input logic [7:0] op);
    op_entry_t e;
    case (op)
      8'h00: e = ent(MN_BRK, AM_IMP);   8'h01: e = ent(MN_ORA, AM_INDX);
      8'h05: e = ent(MN_ORA, AM_ZP);    8'h06: e = ent(MN_ASL, AM_ZP);
      8'h08: e = ent(MN_PHP, AM_IMP);   8'h09: e = ent(MN_ORA, AM_IMM);
      8'h0A: e = ent(MN_ASL, AM_ACC);   8'h0D: e = ent(MN_ORA, AM_ABS);
      8'h0E: e = ent(MN_ASL, AM_ABS);
      8'h10: e = ent(MN_BPL, AM_REL);   8'h11: e = ent(MN_ORA, AM_INDY);
      8'h15: e = ent(MN_ORA, AM_ZPX);   8'h16: e = ent(MN_ASL, AM_ZPX);
      8'h18: e = ent(MN_CLC, AM_IMP);   8'h19: e = ent(MN_ORA, AM_ABSY);
      8'h1D: e = ent(MN_ORA, AM_ABSX);  8'h1E: e = ent(MN_ASL, AM_ABSX);
      8'h20: e = ent(MN_JSR, AM_ABS);   8'h21: e = ent(MN_AND, AM_INDX);
      8'h24: e = ent(MN_BIT, AM_ZP);    8'h25: e = ent(MN_AND, AM_ZP);
      8'h26: e = ent(MN_ROL, AM_ZP);    8'h28: e = ent(MN_PLP, AM_IMP);
      8'h29: e = ent(MN_AND, AM_IMM);   8'h2A: e = ent(MN_ROL, AM_ACC);
      8'h2C: e = ent(MN_BIT, AM_ABS);   8'h2D: e = ent(MN_AND, AM_ABS);
      8'h2E: e = ent(MN_ROL, AM_ABS);
      8'h30: e = ent(MN_BMI, AM_REL);   8'h31: e = ent(MN_AND, AM_INDY);
      8'h35: e = ent(MN_AND, AM_ZPX);   8'h36: e = ent(MN_ROL, AM_ZPX);
      8'h38: e = ent(MN_SEC, AM_IMP);   8'h39: e = ent(MN_AND, AM_ABSY);
      8'h3D: e = ent(MN_AND, AM_ABSX);  8'h3E: e = ent(MN_ROL, AM_ABSX);
      8'h40: e = ent(MN_RTI, AM_IMP);   8'h41: e = ent(MN_EOR, AM_INDX);
      8'h45: e = ent(MN_EOR, AM_ZP);    8'h46: e = ent(MN_LSR, AM_ZP);
      8'h48: e = ent(MN_PHA, AM_IMP);   8'h49: e = ent(MN_EOR, AM_IMM);
      8'h4A: e = ent(MN_LSR, AM_ACC);   8'h4C: e = ent(MN_JMP, AM_ABS);
      8'h4D: e = ent(MN_EOR, AM_ABS);   8'h4E: e = ent(MN_LSR, AM_ABS);
      8'h50: e = ent(MN_BVC, AM_REL);   8'h51: e = ent(MN_EOR, AM_INDY);
      8'h55: e = ent(MN_EOR, AM_ZPX);   8'h56: e = ent(MN_LSR, AM_ZPX);
      8'h58: e = ent(MN_CLI, AM_IMP);   8'h59: e = ent(MN_EOR, AM_ABSY);
      8'h5D: e = ent(MN_EOR, AM_ABSX);  8'h5E: e = ent(MN_LSR, AM_ABSX);
      8'h60: e = ent(MN_RTS, AM_IMP);   8'h61: e = ent(MN_ADC, AM_INDX);
      8'h65: e = ent(MN_ADC, AM_ZP);    8'h66: e = ent(MN_ROR, AM_ZP);
      8'h68: e = ent(MN_PLA, AM_IMP);   8'h69: e = ent(MN_ADC, AM_IMM);
      8'h6A: e = ent(MN_ROR, AM_ACC);   8'h6C: e = ent(MN_JMP, AM_IND);
      8'h6D: e = ent(MN_ADC, AM_ABS);   8'h6E: e = ent(MN_ROR, AM_ABS);
      8'h70: e = ent(MN_BVS, AM_REL);   8'h71: e = ent(MN_ADC, AM_INDY);
      8'h75: e = ent(MN_ADC, AM_ZPX);   8'h76: e = ent(MN_ROR, AM_ZPX);
      8'h78: e = ent(MN_SEI, AM_IMP);   8'h79: e = ent(MN_ADC, AM_ABSY);
      8'h7D: e = ent(MN_ADC, AM_ABSX);  8'h7E: e = ent(MN_ROR, AM_ABSX);
      8'h81: e = ent(MN_STA, AM_INDX);  8'h84: e = ent(MN_STY, AM_ZP);
      8'h85: e = ent(MN_STA, AM_ZP);    8'h86: e = ent(MN_STX, AM_ZP);
      8'h88: e = ent(MN_DEY, AM_IMP);   8'h8A: e = ent(MN_TXA, AM_IMP);
      8'h8C: e = ent(MN_STY, AM_ABS);   8'h8D: e = ent(MN_STA, AM_ABS);
      8'h8E: e = ent(MN_STX, AM_ABS);
      8'h90: e = ent(MN_BCC, AM_REL);   8'h91: e = ent(MN_STA, AM_INDY);
      8'h94: e = ent(MN_STY, AM_ZPX);   8'h95: e = ent(MN_STA, AM_ZPX);
      8'h96: e = ent(MN_STX, AM_ZPY);   8'h98: e = ent(MN_TYA, AM_IMP);
      8'h99: e = ent(MN_STA, AM_ABSY);  8'h9A: e = ent(MN_TXS, AM_IMP);
      8'h9D: e = ent(MN_STA, AM_ABSX);
      8'hA0: e = ent(MN_LDY, AM_IMM);   8'hA1: e = ent(MN_LDA, AM_INDX);
      8'hA2: e = ent(MN_LDX, AM_IMM);   8'hA4: e = ent(MN_LDY, AM_ZP);
      8'hA5: e = ent(MN_LDA, AM_ZP);    8'hA6: e = ent(MN_LDX, AM_ZP);
      8'hA8: e = ent(MN_TAY, AM_IMP);   8'hA9: e = ent(MN_LDA, AM_IMM);
      8'hAA: e = ent(MN_TAX, AM_IMP);   8'hAC: e = ent(MN_LDY, AM_ABS);
      8'hAD: e = ent(MN_LDA, AM_ABS);   8'hAE: e = ent(MN_LDX, AM_ABS);
      8'hB0: e = ent(MN_BCS, AM_REL);   8'hB1: e = ent(MN_LDA, AM_INDY);
      8'hB4: e = ent(MN_LDY, AM_ZPX);   8'hB5: e = ent(MN_LDA, AM_ZPX);
      8'hB6: e = ent(MN_LDX, AM_ZPY);   8'hB8: e = ent(MN_CLV, AM_IMP);
      8'hB9: e = ent(MN_LDA, AM_ABSY);  8'hBA: e = ent(MN_TSX, AM_IMP);
      8'hBC: e = ent(MN_LDY, AM_ABSX);  8'hBD: e = ent(MN_LDA, AM_ABSX);
      8'hBE: e = ent(MN_LDX, AM_ABSY);
      8'hC0: e = ent(MN_CPY, AM_IMM);   8'hC1: e = ent(MN_CMP, AM_INDX);
      8'hC4: e = ent(MN_CPY, AM_ZP);    8'hC5: e = ent(MN_CMP, AM_ZP);
      8'hC6: e = ent(MN_DEC, AM_ZP);    8'hC8: e = ent(MN_INY, AM_IMP);
      8'hC9: e = ent(MN_CMP, AM_IMM);   8'hCA: e = ent(MN_DEX, AM_IMP);
      8'hCC: e = ent(MN_CPY, AM_ABS);   8'hCD: e = ent(MN_CMP, AM_ABS);
      8'hCE: e = ent(MN_DEC, AM_ABS);
      8'hD0: e = ent(MN_BNE, AM_REL);   8'hD1: e = ent(MN_CMP, AM_INDY);
      8'hD5: e = ent(MN_CMP, AM_ZPX);   8'hD6: e = ent(MN_DEC, AM_ZPX);
      8'hD8: e = ent(MN_CLD, AM_IMP);   8'hD9: e = ent(MN_CMP, AM_ABSY);
      8'hDD: e = ent(MN_CMP, AM_ABSX);  8'hDE: e = ent(MN_DEC, AM_ABSX);
      8'hE0: e = ent(MN_CPX, AM_IMM);   8'hE1: e = ent(MN_SBC, AM_INDX);
      8'hE4: e = ent(MN_CPX, AM_ZP);    8'hE5: e = ent(MN_SBC, AM_ZP);
      8'hE6: e = ent(MN_INC, AM_ZP);    8'hE8: e = ent(MN_INX, AM_IMP);
      8'hE9: e = ent(MN_SBC, AM_IMM);   8'hEA: e = ent(MN_NOP, AM_IMP);
      8'hEC: e = ent(MN_CPX, AM_ABS);   8'hED: e = ent(MN_SBC, AM_ABS);
      8'hEE: e = ent(MN_INC, AM_ABS);
      8'hF0: e = ent(MN_BEQ, AM_REL);   8'hF1: e = ent(MN_SBC, AM_INDY);
      8'hF5: e = ent(MN_SBC, AM_ZPX);   8'hF6: e = ent(MN_INC, AM_ZPX);
      8'hF8: e = ent(MN_SED, AM_IMP);   8'hF9: e = ent(MN_SBC, AM_ABSY);
      8'hFD: e = ent(MN_SBC, AM_ABSX);  8'hFE: e = ent(MN_INC, AM_ABSX);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

@@ sv/nmos6502_instruction_predecode_core.sv @@
// ----------------------------------------------------------------------------
// nmos6502_instruction_predecode_core
// NMOS 6502 instruction predecoder: opcode table decode, length clamp and
// operand / branch target extraction, one transaction per cycle while out_stall is low.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_item_t  in_data
//  out_    | output    | out_valid/out_stall | out_item_t out_data
//
//  The input register feeds the decode, which is registered into the result register.
//  Throughput is one transaction per cycle while out_stall is low, set by the single decode stage.
//  Reset clears both valid flags; the payload registers are not reset.
//  out_stall holds the result register; the input register still fills,
//  and in_stall rises only when both registers are occupied.
// ----------------------------------------------------------------------------
module nmos6502_instruction_predecode_core import n6502pd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t dec_res;
  logic      s1_adv;
  logic      in_acc;

  // flow control
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  // decode logic
  n6502pd_decode u_decode (
    .win (s1_data_r),
    .res (dec_res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= dec_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/n6502pd_decode.sv @@
// ----------------------------------------------------------------------------
// n6502pd_decode
// Combinational decode of one instruction window into a result transaction.
// ----------------------------------------------------------------------------
module n6502pd_decode import n6502pd_pkg::*; (
  input  in_item_t  win,
  output out_item_t res
);

  op_entry_t   entry;
  logic [1:0]  tbl_len;
  logic [7:0]  lo_byte;
  logic [15:0] rel_target;

  // table lookup and length
  assign entry   = op_lookup(win.first_byte);
  assign tbl_len = mode_len(entry.mode);

  // second byte reads as zero when missing
  assign lo_byte = (win.bytes_available >= 2'd2) ? win.second_byte : 8'd0;

  // branch target, wraps at 64k
  assign rel_target = win.pc_address + BRANCH_BIAS + {{8{lo_byte[7]}}, lo_byte};

  // result assembly
  always_comb begin
    res = '0;
    res.instr_length = 2'd1;
    if (win.bytes_available == 2'd0) begin
      res.is_data_byte = 1'b1;
    end else if (!entry.valid) begin
      res.is_data_byte = 1'b1;
      res.data_value   = win.first_byte;
    end else begin
      res.instr_length  = (tbl_len > win.bytes_available) ? win.bytes_available : tbl_len;
      res.mnemonic_code = entry.mnem;
      res.address_mode  = entry.mode;
      case (entry.mode)
        AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_INDX, AM_INDY: begin
          res.operand_byte = lo_byte;
        end
        AM_ABS, AM_ABSX, AM_ABSY, AM_IND: begin
          if (win.bytes_available == 2'd3) begin
            res.operand_address = {win.third_byte, win.second_byte};
          end
        end
        AM_REL: begin
          res.operand_address = rel_target;
        end
        default: begin
          res.operand_byte = 8'd0;
        end
      endcase
    end
  end

endmodule

@@ sv/n6502pd_checker.sv @@
// ----------------------------------------------------------------------------
// n6502pd_checker
// Port-level checks on the predecoder's result channel.
// ----------------------------------------------------------------------------
module n6502pd_checker import n6502pd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input stalls only while a result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // data marker is one byte with no decode fields
  a_data_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_data_byte |->
      out_data.instr_length == 2'd1 && out_data.mnemonic_code == 6'd0 &&
      out_data.address_mode == 4'd0 && out_data.operand_byte == 8'd0 &&
      out_data.operand_address == 16'd0)
    else $error("data marker carries decode fields");

  // decoded instruction has legal codes and no data value
  a_decoded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data_byte |->
      out_data.data_value == 8'd0 && out_data.instr_length != 2'd0 &&
      out_data.mnemonic_code <= 6'd55 && out_data.address_mode <= 4'd12)
    else $error("bad decoded result");

endmodule

bind nmos6502_instruction_predecode_core n6502pd_checker u_n6502pd_checker (.*);

@@ tb/tb_nmos6502_instruction_predecode_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmos6502_instruction_predecode_core
// Self-checking bench for the 6502 predecoder. Instruction windows are sent
// through the valid/stall handshake with random gaps on both sides. An
// independent opcode decoder predicts each result, which is checked field by
// field in arrival order.
// ----------------------------------------------------------------------------
module tb_nmos6502_instruction_predecode_core;
  import n6502pd_pkg::*;

  localparam int          CLK_HALF     = 10;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          IDLE_PCT     = 32;

  // decoded opcode: known flag, mnemonic and addressing mode
  typedef struct packed {
    logic   known;
    mnem_t  mnem;
    amode_t mode;
  } opcode_info_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t   decoded_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  int unsigned hold_len    = 0;
  int unsigned hold_seq    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  always #CLK_HALF clk = ~clk;

  nmos6502_instruction_predecode_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // official opcode set; the cc=01 column is fully regular except STA immediate
  function automatic opcode_info_t decode_opcode(input logic [7:0] op);
    opcode_info_t info;
    info = '0;
    if (op[1:0] == 2'b01) begin
      if (op != 8'h89) begin
        info.known = 1'b1;
        case (op[7:5])
          3'd0: info.mnem = MN_ORA;
          3'd1: info.mnem = MN_AND;
          3'd2: info.mnem = MN_EOR;
          3'd3: info.mnem = MN_ADC;
          3'd4: info.mnem = MN_STA;
          3'd5: info.mnem = MN_LDA;
          3'd6: info.mnem = MN_CMP;
          default: info.mnem = MN_SBC;
        endcase
        case (op[4:2])
          3'd0: info.mode = AM_INDX;
          3'd1: info.mode = AM_ZP;
          3'd2: info.mode = AM_IMM;
          3'd3: info.mode = AM_ABS;
          3'd4: info.mode = AM_INDY;
          3'd5: info.mode = AM_ZPX;
          3'd6: info.mode = AM_ABSY;
          default: info.mode = AM_ABSX;
        endcase
      end
    end else begin
      info.known = 1'b1;
      case (op)
        8'h00: begin info.mnem = MN_BRK; info.mode = AM_IMP;  end
        8'h08: begin info.mnem = MN_PHP; info.mode = AM_IMP;  end
        8'h10: begin info.mnem = MN_BPL; info.mode = AM_REL;  end
        8'h18: begin info.mnem = MN_CLC; info.mode = AM_IMP;  end
        8'h20: begin info.mnem = MN_JSR; info.mode = AM_ABS;  end
        8'h24: begin info.mnem = MN_BIT; info.mode = AM_ZP;   end
        8'h28: begin info.mnem = MN_PLP; info.mode = AM_IMP;  end
        8'h2C: begin info.mnem = MN_BIT; info.mode = AM_ABS;  end
        8'h30: begin info.mnem = MN_BMI; info.mode = AM_REL;  end
        8'h38: begin info.mnem = MN_SEC; info.mode = AM_IMP;  end
        8'h40: begin info.mnem = MN_RTI; info.mode = AM_IMP;  end
        8'h48: begin info.mnem = MN_PHA; info.mode = AM_IMP;  end
        8'h4C: begin info.mnem = MN_JMP; info.mode = AM_ABS;  end
        8'h50: begin info.mnem = MN_BVC; info.mode = AM_REL;  end
        8'h58: begin info.mnem = MN_CLI; info.mode = AM_IMP;  end
        8'h60: begin info.mnem = MN_RTS; info.mode = AM_IMP;  end
        8'h68: begin info.mnem = MN_PLA; info.mode = AM_IMP;  end
        8'h6C: begin info.mnem = MN_JMP; info.mode = AM_IND;  end
        8'h70: begin info.mnem = MN_BVS; info.mode = AM_REL;  end
        8'h78: begin info.mnem = MN_SEI; info.mode = AM_IMP;  end
        8'h84: begin info.mnem = MN_STY; info.mode = AM_ZP;   end
        8'h88: begin info.mnem = MN_DEY; info.mode = AM_IMP;  end
        8'h8C: begin info.mnem = MN_STY; info.mode = AM_ABS;  end
        8'h90: begin info.mnem = MN_BCC; info.mode = AM_REL;  end
        8'h94: begin info.mnem = MN_STY; info.mode = AM_ZPX;  end
        8'h98: begin info.mnem = MN_TYA; info.mode = AM_IMP;  end
        8'hA0: begin info.mnem = MN_LDY; info.mode = AM_IMM;  end
        8'hA4: begin info.mnem = MN_LDY; info.mode = AM_ZP;   end
        8'hA8: begin info.mnem = MN_TAY; info.mode = AM_IMP;  end
        8'hAC: begin info.mnem = MN_LDY; info.mode = AM_ABS;  end
        8'hB0: begin info.mnem = MN_BCS; info.mode = AM_REL;  end
        8'hB4: begin info.mnem = MN_LDY; info.mode = AM_ZPX;  end
        8'hB8: begin info.mnem = MN_CLV; info.mode = AM_IMP;  end
        8'hBC: begin info.mnem = MN_LDY; info.mode = AM_ABSX; end
        8'hC0: begin info.mnem = MN_CPY; info.mode = AM_IMM;  end
        8'hC4: begin info.mnem = MN_CPY; info.mode = AM_ZP;   end
        8'hC8: begin info.mnem = MN_INY; info.mode = AM_IMP;  end
        8'hCC: begin info.mnem = MN_CPY; info.mode = AM_ABS;  end
        8'hD0: begin info.mnem = MN_BNE; info.mode = AM_REL;  end
        8'hD8: begin info.mnem = MN_CLD; info.mode = AM_IMP;  end
        8'hE0: begin info.mnem = MN_CPX; info.mode = AM_IMM;  end
        8'hE4: begin info.mnem = MN_CPX; info.mode = AM_ZP;   end
        8'hE8: begin info.mnem = MN_INX; info.mode = AM_IMP;  end
        8'hEC: begin info.mnem = MN_CPX; info.mode = AM_ABS;  end
        8'hF0: begin info.mnem = MN_BEQ; info.mode = AM_REL;  end
        8'hF8: begin info.mnem = MN_SED; info.mode = AM_IMP;  end
        8'h06: begin info.mnem = MN_ASL; info.mode = AM_ZP;   end
        8'h0A: begin info.mnem = MN_ASL; info.mode = AM_ACC;  end
        8'h0E: begin info.mnem = MN_ASL; info.mode = AM_ABS;  end
        8'h16: begin info.mnem = MN_ASL; info.mode = AM_ZPX;  end
        8'h1E: begin info.mnem = MN_ASL; info.mode = AM_ABSX; end
        8'h26: begin info.mnem = MN_ROL; info.mode = AM_ZP;   end
        8'h2A: begin info.mnem = MN_ROL; info.mode = AM_ACC;  end
        8'h2E: begin info.mnem = MN_ROL; info.mode = AM_ABS;  end
        8'h36: begin info.mnem = MN_ROL; info.mode = AM_ZPX;  end
        8'h3E: begin info.mnem = MN_ROL; info.mode = AM_ABSX; end
        8'h46: begin info.mnem = MN_LSR; info.mode = AM_ZP;   end
        8'h4A: begin info.mnem = MN_LSR; info.mode = AM_ACC;  end
        8'h4E: begin info.mnem = MN_LSR; info.mode = AM_ABS;  end
        8'h56: begin info.mnem = MN_LSR; info.mode = AM_ZPX;  end
        8'h5E: begin info.mnem = MN_LSR; info.mode = AM_ABSX; end
        8'h66: begin info.mnem = MN_ROR; info.mode = AM_ZP;   end
        8'h6A: begin info.mnem = MN_ROR; info.mode = AM_ACC;  end
        8'h6E: begin info.mnem = MN_ROR; info.mode = AM_ABS;  end
        8'h76: begin info.mnem = MN_ROR; info.mode = AM_ZPX;  end
        8'h7E: begin info.mnem = MN_ROR; info.mode = AM_ABSX; end
        8'h86: begin info.mnem = MN_STX; info.mode = AM_ZP;   end
        8'h8A: begin info.mnem = MN_TXA; info.mode = AM_IMP;  end
        8'h8E: begin info.mnem = MN_STX; info.mode = AM_ABS;  end
        8'h96: begin info.mnem = MN_STX; info.mode = AM_ZPY;  end
        8'h9A: begin info.mnem = MN_TXS; info.mode = AM_IMP;  end
        8'hA2: begin info.mnem = MN_LDX; info.mode = AM_IMM;  end
        8'hA6: begin info.mnem = MN_LDX; info.mode = AM_ZP;   end
        8'hAA: begin info.mnem = MN_TAX; info.mode = AM_IMP;  end
        8'hAE: begin info.mnem = MN_LDX; info.mode = AM_ABS;  end
        8'hB6: begin info.mnem = MN_LDX; info.mode = AM_ZPY;  end
        8'hBA: begin info.mnem = MN_TSX; info.mode = AM_IMP;  end
        8'hBE: begin info.mnem = MN_LDX; info.mode = AM_ABSY; end
        8'hC6: begin info.mnem = MN_DEC; info.mode = AM_ZP;   end
        8'hCA: begin info.mnem = MN_DEX; info.mode = AM_IMP;  end
        8'hCE: begin info.mnem = MN_DEC; info.mode = AM_ABS;  end
        8'hD6: begin info.mnem = MN_DEC; info.mode = AM_ZPX;  end
        8'hDE: begin info.mnem = MN_DEC; info.mode = AM_ABSX; end
        8'hE6: begin info.mnem = MN_INC; info.mode = AM_ZP;   end
        8'hEA: begin info.mnem = MN_NOP; info.mode = AM_IMP;  end
        8'hEE: begin info.mnem = MN_INC; info.mode = AM_ABS;  end
        8'hF6: begin info.mnem = MN_INC; info.mode = AM_ZPX;  end
        8'hFE: begin info.mnem = MN_INC; info.mode = AM_ABSX; end
        default: info = '0;
      endcase
    end
    return info;
  endfunction

  // expected result for one instruction window
  function automatic out_item_t predict_window(input in_item_t w);
    out_item_t    r;
    opcode_info_t info;
    logic [7:0]   lo;
    logic [1:0]   span;
    r = '0;
    r.instr_length = 2'd1;
    if (w.bytes_available == 2'd0) begin
      r.is_data_byte = 1'b1;
    end else begin
      info = decode_opcode(w.first_byte);
      if (!info.known) begin
        r.is_data_byte = 1'b1;
        r.data_value   = w.first_byte;
      end else begin
        case (info.mode)
          AM_IMP, AM_ACC:                   span = 2'd1;
          AM_ABS, AM_ABSX, AM_ABSY, AM_IND: span = 2'd3;
          default:                          span = 2'd2;
        endcase
        // clamp to the bytes actually present
        r.instr_length  = (span > w.bytes_available) ? w.bytes_available : span;
        r.mnemonic_code = info.mnem;
        r.address_mode  = info.mode;
        lo = (w.bytes_available >= 2'd2) ? w.second_byte : 8'h00;
        case (info.mode)
          AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_INDX, AM_INDY: begin
            r.operand_byte = lo;
          end
          AM_ABS, AM_ABSX, AM_ABSY, AM_IND: begin
            if (w.bytes_available == 2'd3)
              r.operand_address = {w.third_byte, w.second_byte};
          end
          AM_REL: begin
            // sign-extended offset, wraps at 64k
            r.operand_address = w.pc_address + BRANCH_BIAS + {{8{lo[7]}}, lo};
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  // random window, optionally restricted to defined opcodes
  function automatic in_item_t random_window(input bit defined_only);
    in_item_t     w;
    opcode_info_t info;
    w.pc_address  = 16'($urandom);
    w.first_byte  = 8'($urandom);
    w.second_byte = 8'($urandom);
    w.third_byte  = 8'($urandom);
    // bias some addresses to the ends of memory for branch wraparound
    case ($urandom_range(9))
      0: w.pc_address = 16'hFFFF - 16'($urandom_range(0, 3));
      1: w.pc_address = 16'($urandom_range(0, 3));
      default: ;
    endcase
    w.bytes_available = ($urandom_range(99) < 70) ? 2'd3 : 2'($urandom_range(0, 2));
    info = decode_opcode(w.first_byte);
    while (defined_only && !info.known) begin
      w.first_byte = 8'($urandom);
      info = decode_opcode(w.first_byte);
    end
    return w;
  endfunction

  // one input transaction, with idle cycles ahead of it drawn cycle by cycle
  task automatic send_window(input in_item_t w);
    int unsigned gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT)
      gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    decoded_q.push_back(predict_window(w));
  endtask

  task automatic send_bytes(input logic [15:0] pc, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2,
                            input logic [1:0] avail);
    in_item_t w;
    w.pc_address      = pc;
    w.first_byte      = b0;
    w.second_byte     = b1;
    w.third_byte      = b2;
    w.bytes_available = avail;
    send_window(w);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // result checker, in arrival order
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        compare_field("instr_length", want.instr_length, out_data.instr_length);
        compare_field("is_data_byte", want.is_data_byte, out_data.is_data_byte);
        compare_field("data_value", want.data_value, out_data.data_value);
        compare_field("mnemonic_code", want.mnemonic_code, out_data.mnemonic_code);
        compare_field("address_mode", want.address_mode, out_data.address_mode);
        compare_field("operand_byte", want.operand_byte, out_data.operand_byte);
        compare_field("operand_address", want.operand_address,
                      out_data.operand_address);
      end
    end
  end

  // receiver stall: random, off in steady stretches, forced during a hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_nmos6502_instruction_predecode_core failed");
      $finish;
    end
  end

  // empty windows, undefined opcodes, every mode, clamping and branch wrap
  task automatic test_directed_windows();
    send_bytes(16'hFFFF, 8'hEA, 8'hFF, 8'hFF, 2'd0);
    send_bytes(16'h0000, 8'h00, 8'h00, 8'h00, 2'd0);
    send_bytes(16'h0000, 8'h00, 8'hFF, 8'hFF, 2'd3);
    send_bytes(16'h1234, 8'hFF, 8'h12, 8'h34, 2'd3);
    send_bytes(16'h8000, 8'h89, 8'hAA, 8'h55, 2'd1);
    send_bytes(16'h4000, 8'h02, 8'h80, 8'h01, 2'd2);
    send_bytes(16'h0200, 8'h0A, 8'hFF, 8'hFF, 2'd3);
    send_bytes(16'h0300, 8'hA9, 8'hFF, 8'h00, 2'd3);
    send_bytes(16'h0302, 8'hA9, 8'hFF, 8'hFF, 2'd1);
    send_bytes(16'h0400, 8'hA5, 8'h00, 8'hFF, 2'd2);
    send_bytes(16'h0402, 8'hB5, 8'h80, 8'h00, 2'd2);
    send_bytes(16'h0404, 8'h96, 8'h7F, 8'h00, 2'd3);
    send_bytes(16'h0500, 8'hAD, 8'hFF, 8'hFF, 2'd3);
    send_bytes(16'h0503, 8'hAD, 8'h34, 8'h12, 2'd2);
    send_bytes(16'h0506, 8'h9D, 8'h00, 8'h80, 2'd3);
    send_bytes(16'h0509, 8'hBE, 8'h01, 8'h00, 2'd3);
    send_bytes(16'h0600, 8'h6C, 8'hFF, 8'h02, 2'd3);
    send_bytes(16'h0603, 8'h6C, 8'hFF, 8'h02, 2'd1);
    send_bytes(16'h0700, 8'h01, 8'h40, 8'hFF, 2'd3);
    send_bytes(16'h0702, 8'hB1, 8'hFE, 8'hFF, 2'd3);
    send_bytes(16'hFFFF, 8'h10, 8'h7F, 8'hFF, 2'd3);
    send_bytes(16'h0000, 8'hF0, 8'h80, 8'h00, 2'd3);
    send_bytes(16'h1000, 8'hD0, 8'hFE, 8'h00, 2'd3);
    send_bytes(16'hFFFE, 8'h30, 8'h55, 8'h55, 2'd1);
    send_bytes(16'h0800, 8'h20, 8'h00, 8'h80, 2'd3);
  endtask

  // every opcode value once, random surroundings
  task automatic test_opcode_sweep();
    in_item_t w;
    for (int op = 0; op < 256; op++) begin
      w = random_window(1'b0);
      w.first_byte = 8'(op);
      send_window(w);
    end
  endtask

  // back-to-back stream with no gaps on either side
  task automatic test_steady_stream();
    no_idle = 1'b1;
    repeat (60) send_window(random_window(1'b1));
    no_idle = 1'b0;
  endtask

  // long receiver hold-off while the sender keeps going
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_len = 80;
    hold_seq = hold_seq + 1;
    repeat (24) send_window(random_window(1'b1));
    no_idle = 1'b0;
  endtask

  // mostly defined opcodes, some noise
  task automatic test_random_windows();
    repeat (190) send_window(random_window($urandom_range(99) < 85));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_windows();
    test_opcode_sweep();
    test_steady_stream();
    test_backpressure();
    test_random_windows();

    // drain
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_nmos6502_instruction_predecode_core passed");
    end else begin
      $display("tb_nmos6502_instruction_predecode_core failed");
    end
    $finish;
  end

endmodule
